@@ rtl/array_list_shift_engine_assert.svh @@
// Assertion macros shared by the list engine RTL.
// Each check samples on the rising edge of clk and is disabled while rst is high.
`ifndef ARRAY_LIST_SHIFT_ENGINE_ASSERT_SVH
`define ARRAY_LIST_SHIFT_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
`define ALSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ALSE_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define ALSE_ASSERT(lbl, prop, msg)
`define ALSE_ASSERT_IMPL(lbl, pre, post, msg)
`endif

`endif

@@ rtl/alse_pkg.sv @@
package alse_pkg;

  localparam int MAX_ELEMS_DEF = 128;

  localparam int ACT_W = 4;
  localparam int IDX_W = 7;
  localparam int VAL_W = 32;
  localparam int LEN_W = 8;
  localparam int ST_W  = 2;

  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 48;

  localparam logic [ACT_W-1:0] ACT_CLEAR     = 4'd0;
  localparam logic [ACT_W-1:0] ACT_GET       = 4'd1;
  localparam logic [ACT_W-1:0] ACT_SET       = 4'd2;
  localparam logic [ACT_W-1:0] ACT_INS_FIRST = 4'd3;
  localparam logic [ACT_W-1:0] ACT_INS_AT    = 4'd4;
  localparam logic [ACT_W-1:0] ACT_INS_LAST  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_DEL_FIRST = 4'd6;
  localparam logic [ACT_W-1:0] ACT_DEL_AT    = 4'd7;
  localparam logic [ACT_W-1:0] ACT_DEL_LAST  = 4'd8;
  localparam logic [ACT_W-1:0] ACT_SEARCH    = 4'd9;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

endpackage

@@ rtl/alse_ram.sv @@
module alse_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/array_list_shift_engine.sv @@
// Packed list engine: holds up to MAX_ELEMS signed 32-bit words and a count.
// Input channel s_*: one command per transfer (action, index, value).
// Output channel m_*: one result per command (read value, found flag,
// length, empty flag, index checks, status).
// The list lives in a single-port-write, single-port-read memory, and one
// sequencer walks it one entry per cycle; commands are taken one at a time.
// Clear, set, rejected commands and unknown actions skip the memory walk.
// With n the count before the command, a get reads one entry, a search
// reads all n, an insert at position p moves n - p entries and a delete
// at position p moves n - p - 1.
// The next command is taken the cycle after its predecessor's result is
// loaded.
// s_tready is high only while the sequencer is idle; a finished command may
// be accepted while the previous result still waits in the output register.
// If the receiver stalls, the result is held in m_tdata and the sequencer
// waits with the next result until the register frees.
// Reset (rst, synchronous) empties the list and drops any pending result;
// entry contents are not cleared, since only entries below the count are read.
module array_list_shift_engine #(
  parameter int MAX_ELEMS = alse_pkg::MAX_ELEMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // action[3:0], index[10:4], value[42:11], zero[47:43]
  input  logic [alse_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // read_value[31:0], found[32], length[40:33], is_empty[41],
  // index_valid[42], index_effective[43], status[45:44], zero[47:46]
  output logic [alse_pkg::M_DATA_W-1:0] m_tdata
);

  import alse_pkg::*;

  `include "array_list_shift_engine_assert.svh"

  localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CW = $clog2(MAX_ELEMS + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;
  typedef enum logic [1:0] {K_GET, K_SRCH, K_UP, K_DN} kind_t;

  state_t            state, state_next;
  kind_t             kind, kind_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     rem, rem_next;
  logic [AW-1:0]     rd_ptr, rd_ptr_next;
  logic              pend, pend_next;
  logic [AW-1:0]     pend_addr, pend_addr_next;
  logic [AW-1:0]     pos, pos_next;
  logic [VAL_W-1:0]  val, val_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [ST_W-1:0]   status, status_next;
  logic [VAL_W-1:0]  read_value, read_value_next;
  logic              found, found_next;
  logic              m_tvalid_next;
  logic [M_DATA_W-1:0] m_tdata_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [VAL_W-1:0]  rd_data;

  logic [ACT_W-1:0]  in_act;
  logic [IDX_W-1:0]  in_idx;
  logic [VAL_W-1:0]  in_val;
  logic [XW-1:0]     c_x, i_x, p_x;
  logic              full, eff;

  assign in_act = s_tdata[ACT_W-1:0];
  assign in_idx = s_tdata[ACT_W+IDX_W-1:ACT_W];
  assign in_val = s_tdata[ACT_W+IDX_W+VAL_W-1:ACT_W+IDX_W];

  assign c_x  = XW'(count);
  assign i_x  = XW'(in_idx);
  assign full = (count == CW'(MAX_ELEMS));
  assign eff  = (i_x < c_x);

  assign s_tready = (state == S_IDLE);

  alse_ram #(
    .DEPTH (MAX_ELEMS),
    .AW    (AW),
    .DW    (VAL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next      = state;
    kind_next       = kind;
    count_next      = count;
    rem_next        = rem;
    rd_ptr_next     = rd_ptr;
    pend_next       = pend;
    pend_addr_next  = pend_addr;
    pos_next        = pos;
    val_next        = val;
    idx_next        = idx;
    status_next     = status;
    read_value_next = read_value;
    found_next      = found;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = val;
    rd_en           = 1'b0;
    rd_addr         = rd_ptr;
    p_x             = '0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          idx_next        = in_idx;
          val_next        = in_val;
          status_next     = ST_OK;
          read_value_next = '0;
          found_next      = 1'b0;
          pend_next       = 1'b0;
          state_next      = S_FIN;
          case (in_act)
            ACT_CLEAR: begin
              count_next = '0;
            end
            ACT_GET: begin
              if (eff) begin
                kind_next   = K_GET;
                rem_next    = CW'(1);
                rd_ptr_next = AW'(in_idx);
                state_next  = S_RUN;
              end else begin
                status_next = ST_BAD_INDEX;
              end
            end
            ACT_SET: begin
              if (eff) begin
                wr_en   = 1'b1;
                wr_addr = AW'(in_idx);
                wr_data = in_val;
              end else begin
                status_next = ST_BAD_INDEX;
              end
            end
            ACT_INS_FIRST, ACT_INS_AT, ACT_INS_LAST: begin
              if (in_act == ACT_INS_FIRST) begin
                p_x = '0;
              end else if (in_act == ACT_INS_LAST) begin
                p_x = c_x;
              end else begin
                p_x = i_x;
              end
              if (full) begin
                status_next = ST_FULL;
              end else if (p_x > c_x) begin
                status_next = ST_BAD_INDEX;
              end else begin
                kind_next   = K_UP;
                rem_next    = CW'(c_x - p_x);
                rd_ptr_next = AW'(count - CW'(1));
                pos_next    = AW'(p_x);
                state_next  = S_RUN;
              end
            end
            ACT_DEL_FIRST, ACT_DEL_AT, ACT_DEL_LAST: begin
              if (in_act == ACT_DEL_FIRST) begin
                p_x = '0;
              end else if (in_act == ACT_DEL_LAST) begin
                p_x = c_x - XW'(1);
              end else begin
                p_x = i_x;
              end
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else if (p_x >= c_x) begin
                status_next = ST_BAD_INDEX;
              end else begin
                kind_next   = K_DN;
                rem_next    = CW'(c_x - p_x - XW'(1));
                rd_ptr_next = AW'(p_x + XW'(1));
                state_next  = S_RUN;
              end
            end
            ACT_SEARCH: begin
              kind_next   = K_SRCH;
              rem_next    = count;
              rd_ptr_next = '0;
              state_next  = S_RUN;
            end
            default: begin
            end
          endcase
        end
      end

      S_RUN: begin
        // retire the read issued last cycle
        if (pend) begin
          case (kind)
            K_UP: begin
              wr_en   = 1'b1;
              wr_addr = pend_addr + AW'(1);
              wr_data = rd_data;
            end
            K_DN: begin
              wr_en   = 1'b1;
              wr_addr = pend_addr - AW'(1);
              wr_data = rd_data;
            end
            K_SRCH: begin
              if (rd_data == val) begin
                found_next = 1'b1;
              end
            end
            default: begin
              read_value_next = rd_data;
            end
          endcase
        end
        if (rem != '0) begin
          rd_en          = 1'b1;
          rd_addr        = rd_ptr;
          pend_next      = 1'b1;
          pend_addr_next = rd_ptr;
          rd_ptr_next    = (kind == K_UP) ? rd_ptr - AW'(1) : rd_ptr + AW'(1);
          rem_next       = rem - CW'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            // walk done: drop the new word into the gap on insert, or shrink on delete
            if (kind == K_UP) begin
              wr_en      = 1'b1;
              wr_addr    = pos;
              wr_data    = val;
              count_next = count + CW'(1);
            end else if (kind == K_DN) begin
              count_next = count - CW'(1);
            end
            state_next = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = '0;
          m_tdata_next[31:0]  = read_value;
          m_tdata_next[32]    = found;
          m_tdata_next[40:33] = LEN_W'(count);
          m_tdata_next[41]    = (count == '0);
          m_tdata_next[42]    = (XW'(idx) < XW'(MAX_ELEMS));
          m_tdata_next[43]    = (XW'(idx) < XW'(count));
          m_tdata_next[45:44] = status;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      kind     <= K_GET;
      count    <= '0;
      rem      <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      kind     <= kind_next;
      count    <= count_next;
      rem      <= rem_next;
      pend     <= pend_next;
      m_tvalid <= m_tvalid_next;
    end
    rd_ptr     <= rd_ptr_next;
    pend_addr  <= pend_addr_next;
    pos        <= pos_next;
    val        <= val_next;
    idx        <= idx_next;
    status     <= status_next;
    read_value <= read_value_next;
    found      <= found_next;
    m_tdata    <= m_tdata_next;
  end

  `ALSE_ASSERT(a_count_range, count <= CW'(MAX_ELEMS), "element count above capacity")
  `ALSE_ASSERT_IMPL(a_up_not_full, state == S_RUN && kind == K_UP, count < CW'(MAX_ELEMS),
    "shift up started on a full list")
  `ALSE_ASSERT_IMPL(a_idle_no_read, s_tready, !pend, "read outstanding while idle")
  `ALSE_ASSERT_IMPL(a_count_step, !$past(rst) && count != $past(count),
    count == $past(count) + CW'(1) || count == $past(count) - CW'(1) || count == '0,
    "element count moved by more than one")

endmodule
